FILE: sv/gcc_pkg.sv
// Shared constants, types and the helper function of the greedy contact colouring block.
package gcc_pkg;

    localparam int MAX_CONTACTS = 1024;
    localparam int MAX_COLOURS  = 64;
    localparam int BODY_BITS    = 16;

    localparam int IDX_W   = $clog2(MAX_CONTACTS);
    localparam int CNT_W   = $clog2(MAX_CONTACTS + 1);
    localparam int COL_W   = $clog2(MAX_COLOURS);
    localparam int CCNT_W  = $clog2(MAX_COLOURS + 1);
    localparam int ENTRY_W = 2 * BODY_BITS + COL_W;

    localparam int BODY_PORT_W   = 16;
    localparam int COLOUR_PORT_W = 6;
    localparam int CCNT_PORT_W   = 7;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic emit_full;
        logic rd_en;
        logic pick;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last;
    } stat_t;

    typedef struct packed {
        logic             found;
        logic [COL_W-1:0] idx;
    } pick_t;

    function automatic pick_t first_free(input logic [MAX_COLOURS-1:0] taken);
        pick_t r;
        r.found = 1'b0;
        r.idx   = COL_W'(MAX_COLOURS - 1);
        for (int i = MAX_COLOURS - 1; i >= 0; i--)
        begin
            if (!taken[i])
            begin
                r.found = 1'b1;
                r.idx   = COL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/gcc_ram.sv
// Generic simple dual-port RAM with registered read.
module gcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/gcc_ctrl.sv
// Controller state machine: accept, table scan, drain and colour pick sequencing.
module gcc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  gcc_pkg::stat_t stat,
    output gcc_pkg::cmd_t  cmd,
    output logic          busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next    = state_reg;
        busy_next     = busy_reg;
        cmd.load      = 1'b0;
        cmd.emit_full = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.pick      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    priority if (stat.full)
                    begin
                        cmd.emit_full = 1'b1;
                    end
                    else if (stat.empty)
                    begin
                        state_next = ST_PICK;
                        busy_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        busy_next  = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: sv/gcc_datapath.sv
// Datapath: contact table, conflict scan, taken-colour map and result registers.
module gcc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gcc_pkg::cmd_t                        cmd,
    output gcc_pkg::stat_t                       stat,
    input  logic [gcc_pkg::BODY_PORT_W-1:0]      body_a,
    input  logic [gcc_pkg::BODY_PORT_W-1:0]      body_b,
    input  logic                                 start_set,
    output logic                                 done,
    output logic [gcc_pkg::COLOUR_PORT_W-1:0]    colour,
    output logic [gcc_pkg::CCNT_PORT_W-1:0]      colour_count,
    output gcc_pkg::status_t                     status
);

    logic [gcc_pkg::BODY_BITS-1:0]   a_reg, b_reg;
    logic [gcc_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [gcc_pkg::CCNT_W-1:0]      ciu_reg, ciu_next;
    logic [gcc_pkg::IDX_W-1:0]       ptr_reg;
    logic                            rd_vld_reg;
    logic [gcc_pkg::MAX_COLOURS-1:0] taken_reg;
    logic                            done_reg;
    logic [gcc_pkg::COLOUR_PORT_W-1:0] colour_reg;
    logic [gcc_pkg::CCNT_PORT_W-1:0] ccnt_reg;
    gcc_pkg::status_t                status_reg;

    logic [gcc_pkg::ENTRY_W-1:0]     rdata, wdata;
    logic [gcc_pkg::BODY_BITS-1:0]   sa, sb;
    logic [gcc_pkg::COL_W-1:0]       sc;
    logic                            hit;
    gcc_pkg::pick_t                  pick;
    logic [gcc_pkg::CCNT_W-1:0]      c_plus1;

    assign stat.full  = !start_set && (count_reg >= gcc_pkg::CNT_W'(gcc_pkg::MAX_CONTACTS));
    assign stat.empty = start_set || (count_reg == '0);
    assign stat.last  = ({1'b0, ptr_reg} + gcc_pkg::CNT_W'(1)) == count_reg;

    assign sa  = rdata[gcc_pkg::ENTRY_W-1 -: gcc_pkg::BODY_BITS];
    assign sb  = rdata[gcc_pkg::COL_W +: gcc_pkg::BODY_BITS];
    assign sc  = rdata[gcc_pkg::COL_W-1:0];
    assign hit = (sa == a_reg) || (sb == a_reg) || (sa == b_reg) || (sb == b_reg);

    assign pick    = gcc_pkg::first_free(taken_reg);
    assign c_plus1 = gcc_pkg::CCNT_W'(pick.idx) + gcc_pkg::CCNT_W'(1);
    assign wdata   = {a_reg, b_reg, pick.idx};

    always_comb
    begin
        count_next = count_reg;
        ciu_next   = ciu_reg;
        if (cmd.load && start_set)
        begin
            count_next = '0;
            ciu_next   = '0;
        end
        else if (cmd.pick)
        begin
            count_next = count_reg + gcc_pkg::CNT_W'(1);
            if (c_plus1 > ciu_reg)
            begin
                ciu_next = c_plus1;
            end
        end
    end

    gcc_ram #(
        .WIDTH (gcc_pkg::ENTRY_W),
        .DEPTH (gcc_pkg::MAX_CONTACTS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.pick),
        .waddr (count_reg[gcc_pkg::IDX_W-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ciu_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ciu_reg    <= ciu_next;
            rd_vld_reg <= cmd.rd_en;
            done_reg   <= cmd.emit_full || cmd.pick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg     <= gcc_pkg::BODY_BITS'(body_a);
            b_reg     <= gcc_pkg::BODY_BITS'(body_b);
            ptr_reg   <= '0;
            taken_reg <= '0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                ptr_reg <= ptr_reg + gcc_pkg::IDX_W'(1);
            end
            if (rd_vld_reg && hit)
            begin
                taken_reg[sc] <= 1'b1;
            end
        end
        if (cmd.emit_full)
        begin
            colour_reg <= '0;
            ccnt_reg   <= gcc_pkg::CCNT_PORT_W'(ciu_reg);
            status_reg <= gcc_pkg::STATUS_FULL;
        end
        else if (cmd.pick)
        begin
            colour_reg <= gcc_pkg::COLOUR_PORT_W'(pick.idx);
            ccnt_reg   <= gcc_pkg::CCNT_PORT_W'(ciu_next);
            status_reg <= pick.found ? gcc_pkg::STATUS_OK : gcc_pkg::STATUS_EXHAUSTED;
        end
    end

    assign done         = done_reg;
    assign colour       = colour_reg;
    assign colour_count = ccnt_reg;
    assign status       = status_reg;

endmodule

FILE: sv/greedy_contact_colouring.sv
// Top level of the greedy contact colouring block.
//
//  channel   handshake          payload
//  -------   ----------------   --------------------------------------
//  command   start / busy       body_a, body_b, start_set
//  result    done (1 cycle)     colour, colour_count, status
//
// A contact goes through accept, one table read per stored contact through the
// single read port, a drain state and a pick state.
// An empty set goes from accept straight to the pick state; a full table answers the cycle after accept.
// Reset empties the set at once; table contents need no clearing.
// The result shows for one cycle after the pick; a new contact may start then.
module greedy_contact_colouring (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gcc_pkg::BODY_PORT_W-1:0]   body_a,
    input  logic [gcc_pkg::BODY_PORT_W-1:0]   body_b,
    input  logic                              start_set,
    output logic                              done,
    output logic [gcc_pkg::COLOUR_PORT_W-1:0] colour,
    output logic [gcc_pkg::CCNT_PORT_W-1:0]   colour_count,
    output logic [1:0]                        status
);

    gcc_pkg::cmd_t    cmd;
    gcc_pkg::stat_t   stat;
    gcc_pkg::status_t status_w;

    gcc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    gcc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .body_a       (body_a),
        .body_b       (body_b),
        .start_set    (start_set),
        .done         (done),
        .colour       (colour),
        .colour_count (colour_count),
        .status       (status_w)
    );

    assign status = status_w;

endmodule

FILE: test/tb_greedy_contact_colouring.sv
// Testbench for greedy_contact_colouring: directed, table-fill and random contact sets.
module tb_greedy_contact_colouring;
    timeunit 1ns;
    timeprecision 1ps;

    import gcc_pkg::*;

    localparam int IDLE_PCT   = 35;
    localparam int RANDOM_CNT = 580;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic [COLOUR_PORT_W-1:0] colour;
        logic [CCNT_PORT_W-1:0]   colour_count;
        status_t                  status;
    } colour_result_t;

    typedef struct {
        logic [BODY_PORT_W-1:0] a;
        logic [BODY_PORT_W-1:0] b;
        logic                   fresh_set;
        bit                     eager;
    } contact_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [BODY_PORT_W-1:0]   body_a;
    logic [BODY_PORT_W-1:0]   body_b;
    logic                     start_set;
    logic                     done;
    logic [COLOUR_PORT_W-1:0] colour;
    logic [CCNT_PORT_W-1:0]   colour_count;
    logic [1:0]               status;

    greedy_contact_colouring dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .body_a       (body_a),
        .body_b       (body_b),
        .start_set    (start_set),
        .done         (done),
        .colour       (colour),
        .colour_count (colour_count),
        .status       (status)
    );

    logic [BODY_BITS-1:0] held_a [MAX_CONTACTS];
    logic [BODY_BITS-1:0] held_b [MAX_CONTACTS];
    logic [COL_W-1:0]     held_colour [MAX_CONTACTS];
    int                   held_count;
    int                   colours_used;

    contact_t             pending_contacts [$];
    colour_result_t       colours_due [$];
    logic [BODY_PORT_W-1:0] body_pool [$];

    logic                 took_cmd;
    int                   mismatches;
    int                   stall_cycles;
    bit                   moved;
    colour_result_t       due;

    function automatic colour_result_t assign_colour(input logic [BODY_PORT_W-1:0] in_a,
                                                     input logic [BODY_PORT_W-1:0] in_b,
                                                     input logic fresh);
        colour_result_t       r;
        logic [BODY_BITS-1:0] a;
        logic [BODY_BITS-1:0] b;
        logic [MAX_COLOURS-1:0] in_use;
        int                   c;
        a = in_a[BODY_BITS-1:0];
        b = in_b[BODY_BITS-1:0];
        if (fresh)
        begin
            held_count   = 0;
            colours_used = 0;
        end
        if (held_count >= MAX_CONTACTS)
        begin
            r.colour       = '0;
            r.colour_count = CCNT_PORT_W'(colours_used);
            r.status       = STATUS_FULL;
            return r;
        end
        in_use = '0;
        for (int j = 0; j < held_count; j++)
        begin
            if (held_a[j] == a || held_b[j] == a || held_a[j] == b || held_b[j] == b)
                in_use[held_colour[j]] = 1'b1;
        end
        c = 0;
        while (c < MAX_COLOURS && in_use[c])
            c++;
        r.status = STATUS_OK;
        if (c >= MAX_COLOURS)
        begin
            c        = MAX_COLOURS - 1;
            r.status = STATUS_EXHAUSTED;
        end
        held_a[held_count]      = a;
        held_b[held_count]      = b;
        held_colour[held_count] = COL_W'(c);
        held_count++;
        if (c + 1 > colours_used)
            colours_used = c + 1;
        r.colour       = COLOUR_PORT_W'(c);
        r.colour_count = CCNT_PORT_W'(colours_used);
        return r;
    endfunction

    task automatic push_contact(input logic [BODY_PORT_W-1:0] a, input logic [BODY_PORT_W-1:0] b,
                                input logic fresh, input bit eager);
        contact_t t;
        t.a         = a;
        t.b         = b;
        t.fresh_set = fresh;
        t.eager     = eager;
        pending_contacts.push_back(t);
    endtask

    task automatic refill_pool(input int n);
        int r;
        body_pool.delete();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(7);
            if (r == 0)
                body_pool.push_back('0);
            else if (r == 1)
                body_pool.push_back('1);
            else
                body_pool.push_back(BODY_PORT_W'($urandom()));
        end
    endtask

    function automatic logic [BODY_PORT_W-1:0] pick_body();
        if ($urandom_range(9) < 8)
            return body_pool[$urandom_range(body_pool.size() - 1)];
        return BODY_PORT_W'($urandom());
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        body_a    = '0;
        body_b    = '0;
        start_set = 1'b0;
    end

    // drive the command side; hold start until the transfer completes
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took_cmd)
        begin
            if (pending_contacts.size() != 0 &&
                (pending_contacts[0].eager || $urandom_range(99) >= IDLE_PCT))
            begin
                body_a    <= pending_contacts[0].a;
                body_b    <= pending_contacts[0].b;
                start_set <= pending_contacts[0].fresh_set;
                start     <= 1'b1;
                void'(pending_contacts.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            took_cmd     <= 1'b0;
            stall_cycles = 0;
        end
        else
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                if (colours_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result, colour %0d count %0d status %0d",
                                 $time, colour, colour_count, status);
                end
                else
                begin
                    due = colours_due.pop_front();
                    check_field("colour", due.colour, colour);
                    check_field("colour_count", due.colour_count, colour_count);
                    check_field("status", due.status, status);
                end
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                colours_due.push_back(assign_colour(body_a, body_b, start_set));
            end
            took_cmd <= start && !busy;
            if (moved)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int made;
        int set_len;
        bit fresh;
        mismatches   = 0;
        held_count   = 0;
        colours_used = 0;

        push_contact(16'h0000, 16'h0000, 1'b1, 1'b0);
        push_contact(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        push_contact(16'h0000, 16'hFFFF, 1'b0, 1'b0);
        push_contact(16'h5555, 16'hAAAA, 1'b0, 1'b0);
        push_contact(16'hAAAA, 16'h5555, 1'b0, 1'b0);
        push_contact(16'h0001, 16'h0002, 1'b0, 1'b0);
        push_contact(16'h0002, 16'h0003, 1'b0, 1'b0);
        push_contact(16'h0003, 16'h0001, 1'b0, 1'b0);
        push_contact(16'h8000, 16'h0001, 1'b0, 1'b0);
        push_contact(16'h0001, 16'h8000, 1'b0, 1'b0);
        push_contact(16'h0000, 16'h0000, 1'b1, 1'b0);
        push_contact(16'h0000, 16'h0000, 1'b1, 1'b0);
        push_contact(16'h1234, 16'h1234, 1'b0, 1'b0);
        push_contact(16'h1234, 16'h4321, 1'b0, 1'b0);
        push_contact(16'h4321, 16'h1234, 1'b0, 1'b0);
        push_contact(16'h0001, 16'hFFFE, 1'b1, 1'b0);
        push_contact(16'h7FFF, 16'h8000, 1'b0, 1'b0);
        push_contact(16'hFFFE, 16'h7FFF, 1'b0, 1'b0);

        // fill the table; a shared body drives the colours to exhaustion
        push_contact(16'h0000, BODY_PORT_W'($urandom()), 1'b1, 1'b0);
        for (int k = 1; k < 70; k++)
            push_contact(16'h0000, BODY_PORT_W'($urandom()), 1'b0, 1'b0);
        refill_pool(6);
        for (int k = 70; k < MAX_CONTACTS; k++)
            push_contact(pick_body(), pick_body(), 1'b0, 1'b0);
        push_contact(16'hFFFF, 16'h0000, 1'b0, 1'b0);
        push_contact(BODY_PORT_W'($urandom()), BODY_PORT_W'($urandom()), 1'b0, 1'b0);
        push_contact(16'h0000, 16'hFFFF, 1'b0, 1'b0);
        push_contact(16'h0042, 16'h0042, 1'b1, 1'b0);

        made = 0;
        while (made < RANDOM_CNT)
        begin
            set_len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            refill_pool($urandom_range(2, 12));
            for (int k = 0; k < set_len && made < RANDOM_CNT; k++)
            begin
                fresh = (k == 0) || ($urandom_range(39) == 0);
                push_contact(pick_body(), pick_body(), fresh, made >= 200 && made < 320);
                made++;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_contacts.size() != 0 || start)
            @(posedge clk);
        while (colours_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && colours_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
